### sv/kbpi_pkg.sv
// ----------------------------------------------------------------------------
// kbpi_pkg: shared types and constants for the bicycle pose integrator
// Fixed-point constants, datapath widths, sequencer states and CORDIC table.
// ----------------------------------------------------------------------------
package kbpi_pkg;

   // fixed-point constants
   localparam int TWO_PI_Q12   = 25736;
   localparam int PI_Q16       = 205887;
   localparam int TWO_PI_Q16   = 411775;
   localparam int HALF_PI_Q16  = 102944;
   localparam int CORDIC_GAIN  = 39797;
   localparam int CORDIC_STEPS = 16;
   localparam int STEER_LIMIT  = 6000;
   localparam int SPEED_RESET  = 896;
   localparam int WB_RESET     = 691;
   localparam int MST_RESET    = 6554;

   // heading modulo by reciprocal: floor(2^32 / 2pi_q12), quotient low by at most one
   localparam int MOD_SHIFT = 32;
   localparam int MOD_RECIP = int'((64'd1 << MOD_SHIFT) / 64'(TWO_PI_Q12));

   // datapath widths
   localparam int ANG_W = 21;   // CORDIC angle, Q16 radians
   localparam int CV_W  = 20;   // CORDIC vector
   localparam int MA_W  = 34;   // multiplier operand a
   localparam int MB_W  = 19;   // multiplier operand b
   localparam int MP_W  = 53;   // multiplier product
   localparam int DVD_W = 52;   // divider dividend / quotient
   localparam int DSR_W = 38;   // divider divisor / remainder
   localparam int CNT_W = $clog2(DVD_W);
   localparam int ITER_W = $clog2(CORDIC_STEPS);

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [CV_W-1:0]  cv_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORD_H,
      ST_CORD_S,
      ST_MUL,
      ST_DIV_B,
      ST_MOD,
      ST_DONE
   } state_type;

   typedef enum logic {
      REG_WHEELBASE = 1'b0,
      REG_MAX_STEP  = 1'b1
   } reg_type;

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   // divider result bundle
   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_res_type;

   // arctangent of 2^-i in Q16
   function automatic ang_type atan_q16(input logic [ITER_W-1:0] i);
      ang_type r;
      unique case (i)
         4'd0:    r = ANG_W'(51472);
         4'd1:    r = ANG_W'(30386);
         4'd2:    r = ANG_W'(16055);
         4'd3:    r = ANG_W'(8150);
         4'd4:    r = ANG_W'(4091);
         4'd5:    r = ANG_W'(2047);
         4'd6:    r = ANG_W'(1024);
         4'd7:    r = ANG_W'(512);
         4'd8:    r = ANG_W'(256);
         4'd9:    r = ANG_W'(128);
         4'd10:   r = ANG_W'(64);
         4'd11:   r = ANG_W'(32);
         4'd12:   r = ANG_W'(16);
         4'd13:   r = ANG_W'(8);
         4'd14:   r = ANG_W'(4);
         default: r = ANG_W'(2);
      endcase
      return r;
   endfunction

endpackage

### sv/kinematic_bicycle_pose_integrator.sv
// ----------------------------------------------------------------------------
// kinematic_bicycle_pose_integrator: Euler-step bicycle model pose tracker
// Keeps x, y, heading and speed; load items set them, step items advance them.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    op, elapsed_time, steer, accel, load_*
//  rsp      out        rsp_valid/stall    pos_x, pos_y, heading, speed
//  csr      in         APB, pready high   wheelbase, max_step_time
//
//  A step transaction makes two CORDIC passes (heading, then steer), uses the
//  shared multiplier, then the serial divider (steering term), then the
//  shared multiplier again for the heading modulo; its result then enters the
//  output register. A load goes through the done state to the output
//  register. req_stall is high from acceptance until the result enters the
//  output register; the output register waits on rsp_stall. Sync reset.
// ----------------------------------------------------------------------------
module kinematic_bicycle_pose_integrator (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [15:0]        req_elapsed_time,
   input  logic signed [13:0] req_steer_angle,
   input  logic signed [15:0] req_accel_cmd,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [15:0] req_load_heading,
   input  logic [15:0]        req_load_speed,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [15:0] rsp_heading,
   output logic [15:0]        rsp_speed,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import kbpi_pkg::*;

   localparam logic signed [15:0] K_STEER = 16'(STEER_LIMIT);
   localparam logic [16:0]        K_2PI   = 17'(TWO_PI_Q12);
   localparam logic [31:0]        K_MOD   = 32'(TWO_PI_Q12);

   // configuration registers
   logic [15:0] wb_cfg_ff, mst_cfg_ff;
   reg_type     csr_idx;
   logic        csr_wr;

   assign csr_idx    = reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_cfg_ff  <= 16'(WB_RESET);
         mst_cfg_ff <= 16'(MST_RESET);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WHEELBASE: wb_cfg_ff  <= csr_pwdata[15:0];
            REG_MAX_STEP:  mst_cfg_ff <= csr_pwdata[15:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_WHEELBASE: csr_prdata = {16'b0, wb_cfg_ff};
         REG_MAX_STEP:  csr_prdata = {16'b0, mst_cfg_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // control and state registers
   state_type          state_ff, state_in;
   logic [2:0]         mstep_ff, mstep_in;
   logic signed [31:0] cur_x_ff, cur_y_ff;
   logic signed [15:0] cur_h_ff;
   logic [15:0]        cur_v_ff;
   logic signed [31:0] res_x_ff, res_y_ff;
   logic signed [15:0] res_h_ff;
   logic [15:0]        res_v_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic signed [15:0] rsp_h_ff;
   logic [15:0]        rsp_v_ff;

   // latched step operands and intermediates
   logic [15:0]             dt_ff, wb_ff;
   logic signed [15:0]      steer_ff, accel_ff;
   logic signed [MB_W-1:0]  hc_ff, hs_ff, sc_ff, ss_ff;
   logic [MA_W-1:0]         dv_ff;
   logic signed [32:0]      pa_ff;
   logic [DSR_W-1:0]        den_ff;
   logic signed [MP_W-1:0]  px_ff, py_ff;
   logic                    num_neg_ff, sum_neg_ff;
   logic [31:0]             hm_ff;   // |heading sum|, below 2^32 over the input range

   logic                    req_acc;
   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // shared units
   logic                   cord_start;
   logic signed [15:0]     cord_angle;
   logic                   cord_done;
   cv_type                 cord_cos, cord_sin;
   logic                   div_start;
   logic [DVD_W-1:0]       div_dvd;
   logic [DSR_W-1:0]       div_dsr;
   div_res_type            div_res;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p;

   kbpi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .done    (cord_done),
      .cos_out (cord_cos),
      .sin_out (cord_sin)
   );

   kbpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .result   (div_res)
   );

   kbpi_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   // request conditioning: clamp time and steer, guard wheel base
   logic [15:0]        dt_c, wb_c;
   logic signed [15:0] steer_x, steer_c;
   always_comb begin
      dt_c    = (req_elapsed_time > mst_cfg_ff) ? mst_cfg_ff : req_elapsed_time;
      wb_c    = (wb_cfg_ff == 16'd0) ? 16'd1 : wb_cfg_ff;
      steer_x = {{2{req_steer_angle[13]}}, req_steer_angle};
      if (steer_x > K_STEER) begin
         steer_c = K_STEER;
      end else if (steer_x < -K_STEER) begin
         steer_c = -K_STEER;
      end else begin
         steer_c = steer_x;
      end
   end

   // loaded heading: truncated modulo 2pi, one subtract covers 16-bit range
   logic [16:0]        lh_mag, lh_red;
   logic signed [15:0] lh_wrap;
   always_comb begin
      lh_mag  = req_load_heading[15] ? -{1'b1, req_load_heading}
                                     : {1'b0, req_load_heading};
      lh_red  = (lh_mag >= K_2PI) ? (lh_mag - K_2PI) : lh_mag;
      lh_wrap = req_load_heading[15] ? -16'(lh_red) : 16'(lh_red);
   end

   // multiplier operand schedule
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MOD) begin
         // reciprocal estimate of the quotient, then quotient times 2pi
         if (mstep_ff == 3'd0) begin
            mul_a = {2'b0, hm_ff};
            mul_b = MB_W'(MOD_RECIP);
         end else begin
            mul_a = MA_W'(mul_p[MOD_SHIFT+17:MOD_SHIFT]);
            mul_b = MB_W'(TWO_PI_Q12);
         end
      end else begin
         unique case (mstep_ff)
            3'd0: begin
               mul_a = {18'b0, dt_ff};
               mul_b = {3'b0, cur_v_ff};
            end
            3'd1: begin
               mul_a = {18'b0, dt_ff};
               mul_b = {{3{accel_ff[15]}}, accel_ff};
            end
            3'd2: begin
               mul_a = {18'b0, wb_ff};
               mul_b = sc_ff;
            end
            3'd3: begin
               mul_a = dv_ff;
               mul_b = hc_ff;
            end
            3'd4: begin
               mul_a = dv_ff;
               mul_b = hs_ff;
            end
            3'd5: begin
               mul_a = dv_ff;
               mul_b = ss_ff;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   // steering term sign-magnitude, heading sum and its remainder
   logic [MP_W-1:0]        num_mag;
   logic signed [MP_W-1:0] beta, hsum, hsum_mag;
   logic [31:0]            mod_r, h_rem;
   logic signed [15:0]     h_wrap;
   always_comb begin
      num_mag  = mul_p[MP_W-1] ? -mul_p : mul_p;
      beta     = num_neg_ff ? -MP_W'(div_res.quotient) : MP_W'(div_res.quotient);
      hsum     = MP_W'(cur_h_ff) + beta;
      hsum_mag = hsum[MP_W-1] ? -hsum : hsum;
      // estimate is at most one short, so one correction
      mod_r    = hm_ff - mul_p[31:0];
      h_rem    = (mod_r >= K_MOD) ? (mod_r - K_MOD) : mod_r;
      h_wrap   = sum_neg_ff ? -16'(h_rem) : 16'(h_rem);
   end

   // position and speed updates, truncated toward zero
   logic [MP_W-1:0]     pxm, pym;
   logic signed [33:0]  dx, dy, nx, ny;
   logic signed [31:0]  sx, sy;
   logic [32:0]         pam;
   logic signed [18:0]  dvv, nsp;
   logic [15:0]         sv;
   always_comb begin
      pxm = px_ff[MP_W-1] ? -px_ff : px_ff;
      pym = py_ff[MP_W-1] ? -py_ff : py_ff;
      dx  = px_ff[MP_W-1] ? -34'(pxm >> 24) : 34'(pxm >> 24);
      dy  = py_ff[MP_W-1] ? -34'(pym >> 24) : 34'(pym >> 24);
      nx  = 34'(cur_x_ff) + dx;
      ny  = 34'(cur_y_ff) + dy;
      if (nx > 34'sd2147483647) begin
         sx = 32'sh7fffffff;
      end else if (nx < -34'sd2147483648) begin
         sx = 32'sh80000000;
      end else begin
         sx = nx[31:0];
      end
      if (ny > 34'sd2147483647) begin
         sy = 32'sh7fffffff;
      end else if (ny < -34'sd2147483648) begin
         sy = 32'sh80000000;
      end else begin
         sy = ny[31:0];
      end
      pam = pa_ff[32] ? -pa_ff : pa_ff;
      dvv = pa_ff[32] ? -19'(pam >> 16) : 19'(pam >> 16);
      nsp = {3'b0, cur_v_ff} + dvv;
      if (nsp < 0) begin
         sv = 16'd0;
      end else if (nsp > 19'sd65535) begin
         sv = 16'hffff;
      end else begin
         sv = nsp[15:0];
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: next state and unit starts
   always_comb begin
      state_in   = state_ff;
      mstep_in   = mstep_ff;
      cord_start = 1'b0;
      cord_angle = cur_h_ff;
      div_start  = 1'b0;
      div_dvd    = num_mag[DVD_W-1:0];
      div_dsr    = den_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (op_type'(req_op) == OP_LOAD) begin
                  state_in = ST_DONE;
               end else begin
                  cord_start = 1'b1;
                  state_in   = ST_CORD_H;
               end
            end
         end
         ST_CORD_H: begin
            cord_angle = steer_ff;
            if (cord_done) begin
               cord_start = 1'b1;
               state_in   = ST_CORD_S;
            end
         end
         ST_CORD_S: begin
            cord_angle = steer_ff;
            if (cord_done) begin
               mstep_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd6) begin
               div_start = 1'b1;
               state_in  = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_res.done) begin
               mstep_in = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd2) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
      end
   end

   // datapath captures
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_acc) begin
         dt_ff    <= dt_c;
         wb_ff    <= wb_c;
         steer_ff <= steer_c;
         accel_ff <= req_accel_cmd;
         res_x_ff <= req_load_x;
         res_y_ff <= req_load_y;
         res_h_ff <= lh_wrap;
         res_v_ff <= req_load_speed;
      end
      if (state_ff == ST_CORD_H && cord_done) begin
         hc_ff <= cord_cos[MB_W-1:0];
         hs_ff <= cord_sin[MB_W-1:0];
      end
      if (state_ff == ST_CORD_S && cord_done) begin
         sc_ff <= (cord_cos < 1) ? MB_W'(1) : cord_cos[MB_W-1:0];
         ss_ff <= cord_sin[MB_W-1:0];
      end
      if (state_ff == ST_MUL) begin
         unique case (mstep_ff)
            3'd1:    dv_ff  <= mul_p[MA_W-1:0];
            3'd2:    pa_ff  <= mul_p[32:0];
            3'd3:    den_ff <= {mul_p[DSR_W-5:0], 4'b0000};
            3'd4:    px_ff  <= mul_p;
            3'd5:    py_ff  <= mul_p;
            3'd6:    num_neg_ff <= mul_p[MP_W-1];
            default: ;
         endcase
      end
      if (state_ff == ST_DIV_B && div_res.done) begin
         sum_neg_ff <= hsum[MP_W-1];
         hm_ff      <= hsum_mag[31:0];
      end
      if (state_ff == ST_MOD && mstep_ff == 3'd2) begin
         res_x_ff <= sx;
         res_y_ff <= sy;
         res_h_ff <= h_wrap;
         res_v_ff <= sv;
      end
   end

   // pose state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_h_ff     <= '0;
         cur_v_ff     <= 16'(SPEED_RESET);
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         cur_x_ff     <= res_x_ff;
         cur_y_ff     <= res_y_ff;
         cur_h_ff     <= res_h_ff;
         cur_v_ff     <= res_v_ff;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_x_ff <= res_x_ff;
         rsp_y_ff <= res_y_ff;
         rsp_h_ff <= res_h_ff;
         rsp_v_ff <= res_v_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_x_ff;
   assign rsp_pos_y   = rsp_y_ff;
   assign rsp_heading = rsp_h_ff;
   assign rsp_speed   = rsp_v_ff;

endmodule

### sv/kbpi_cordic.sv
// ----------------------------------------------------------------------------
// kbpi_cordic: iterative rotation CORDIC
// Takes a Q3.12 angle, returns cos and sin in Q16 after one step per cycle.
// ----------------------------------------------------------------------------
module kbpi_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [15:0]    angle,
   output logic                  done,
   output kbpi_pkg::cv_type      cos_out,
   output kbpi_pkg::cv_type      sin_out
);
   import kbpi_pkg::*;

   localparam ang_type K_PI      = ANG_W'(PI_Q16);
   localparam ang_type K_TWO_PI  = ANG_W'(TWO_PI_Q16);
   localparam ang_type K_HALF_PI = ANG_W'(HALF_PI_Q16);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              flip_ff, flip_in;
   cv_type            x_ff, x_in, y_ff, y_in;
   ang_type           z_ff, z_in;

   ang_type z0, zr;
   logic    fl;
   cv_type  sx, sy;
   ang_type at;

   // range reduction into [-pi/2, pi/2]
   always_comb begin
      z0 = {angle[15], angle, 4'b0000};
      zr = z0;
      fl = 1'b0;
      if (zr > K_PI) begin
         zr = zr - K_TWO_PI;
      end else if (zr < -K_PI) begin
         zr = zr + K_TWO_PI;
      end
      if (zr > K_HALF_PI) begin
         zr = zr - K_PI;
         fl = 1'b1;
      end else if (zr < -K_HALF_PI) begin
         zr = zr + K_PI;
         fl = 1'b1;
      end
   end

   // one micro-rotation per cycle
   always_comb begin
      sx      = x_ff >>> cnt_ff;
      sy      = y_ff >>> cnt_ff;
      at      = atan_q16(cnt_ff);
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         flip_in = fl;
         x_in    = CV_W'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = zr;
      end else if (run_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_W'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

### sv/kbpi_div.sv
// ----------------------------------------------------------------------------
// kbpi_div: serial restoring divider
// Unsigned quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kbpi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kbpi_pkg::DVD_W-1:0]    dividend,
   input  logic [kbpi_pkg::DSR_W-1:0]    divisor,
   output kbpi_pkg::div_res_type         result
);
   import kbpi_pkg::*;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   trial;
   logic [DSR_W:0]   diff;

   // shift, trial subtract, restore
   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[DSR_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DSR_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = dvd_ff;

endmodule

### sv/kbpi_mul.sv
// ----------------------------------------------------------------------------
// kbpi_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module kbpi_mul (
   input  logic                              clock,
   input  logic signed [kbpi_pkg::MA_W-1:0]  op_a,
   input  logic signed [kbpi_pkg::MB_W-1:0]  op_b,
   output logic signed [kbpi_pkg::MP_W-1:0]  product
);
   import kbpi_pkg::*;

   logic signed [MP_W-1:0] p_ff, p_in;

   // operands sign-extend to product width
   assign p_in = op_a * op_b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign product = p_ff;

endmodule

### tb/kinematic_bicycle_pose_integrator_tb.sv
// ----------------------------------------------------------------------------
// kinematic_bicycle_pose_integrator_tb: self-checking bench for pose integrator
// Drives load and step transactions under varied idle and stall patterns,
// predicts each resulting pose in fixed point and checks it field by field.
// ----------------------------------------------------------------------------
module kinematic_bicycle_pose_integrator_tb;
   import kbpi_pkg::*;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic [15:0]        speed;
   } pose_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = 1'b0;
   logic [15:0]        req_elapsed_time = '0;
   logic signed [13:0] req_steer_angle = '0;
   logic signed [15:0] req_accel_cmd = '0;
   logic signed [31:0] req_load_x = '0;
   logic signed [31:0] req_load_y = '0;
   logic signed [15:0] req_load_heading = '0;
   logic [15:0]        req_load_speed = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [15:0] rsp_heading;
   logic [15:0]        rsp_speed;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   kinematic_bicycle_pose_integrator DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted state and registers
   longint   wb_q, mst_q, px_q, py_q, hd_q, sp_q;
   pose_type pose_fifo[$];
   int       errors = 0;
   int       send_idle_pct = 0;
   int       rsp_stall_pct = 0;
   longint   cycles = 0;
   localparam longint CYCLE_LIMIT = 4000000;

   // floor shift of a signed value
   function automatic longint fshift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint atan_tab(int i);
      longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
      return t[i];
   endfunction

   // 16-step rotation CORDIC, Q3.12 angle in, Q16 cos/sin out
   task automatic cordic_sincos(input longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      z = ang * 16;
      x = CORDIC_GAIN;
      y = 0;
      flip = 0;
      while (z > PI_Q16) z -= TWO_PI_Q16;
      while (z < -PI_Q16) z += TWO_PI_Q16;
      if (z > HALF_PI_Q16) begin
         z -= PI_Q16; flip = 1;
      end else if (z < -HALF_PI_Q16) begin
         z += PI_Q16; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - fshift(y, i);
            y = y + fshift(x, i);
            z -= atan_tab(i);
         end else begin
            nx = x + fshift(y, i);
            y = y - fshift(x, i);
            z += atan_tab(i);
         end
         x = nx;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endtask

   // advance the predicted pose by one transaction
   task automatic predict_pose(input logic op, input logic [15:0] et,
                               input logic signed [13:0] st, input logic signed [15:0] ac,
                               input logic signed [31:0] lx, input logic signed [31:0] ly,
                               input logic signed [15:0] lh, input logic [15:0] ls);
      longint   dt, steer, wb, hc, hs, sc, ss, dv, beta, ns;
      pose_type p;
      if (op == OP_LOAD) begin
         px_q = lx;
         py_q = ly;
         hd_q = longint'(lh) % TWO_PI_Q12;
         sp_q = ls;
      end else begin
         dt = et;
         if (dt > mst_q) dt = mst_q;
         wb = (wb_q < 1) ? 1 : wb_q;
         steer = st;
         if (steer > STEER_LIMIT) steer = STEER_LIMIT;
         if (steer < -STEER_LIMIT) steer = -STEER_LIMIT;
         cordic_sincos(hd_q, hc, hs);
         cordic_sincos(steer, sc, ss);
         if (sc < 1) sc = 1;
         dv = dt * sp_q;
         beta = (dv * ss) / (sc * wb * 16);
         px_q = sat32(px_q + (dv * hc) / 16777216);
         py_q = sat32(py_q + (dv * hs) / 16777216);
         hd_q = (hd_q + beta) % TWO_PI_Q12;
         ns = sp_q + (dt * longint'(ac)) / 65536;
         if (ns < 0) ns = 0;
         if (ns > 65535) ns = 65535;
         sp_q = ns;
      end
      p.pos_x = px_q[31:0];
      p.pos_y = py_q[31:0];
      p.heading = hd_q[15:0];
      p.speed = sp_q[15:0];
      pose_fifo = {pose_fifo, p};
   endtask

   // send one transaction, predicting at acceptance
   task automatic send_item(input logic op, input logic [15:0] et,
                            input logic signed [13:0] st, input logic signed [15:0] ac,
                            input logic signed [31:0] lx, input logic signed [31:0] ly,
                            input logic signed [15:0] lh, input logic [15:0] ls);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_elapsed_time <= et;
      req_steer_angle <= st;
      req_accel_cmd <= ac;
      req_load_x <= lx;
      req_load_y <= ly;
      req_load_heading <= lh;
      req_load_speed <= ls;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pose(op, et, st, ac, lx, ly, lh, ls);
   endtask

   task automatic send_load(input logic signed [31:0] lx, input logic signed [31:0] ly,
                            input logic signed [15:0] lh, input logic [15:0] ls);
      send_item(OP_LOAD, 16'($urandom), 14'($urandom), 16'($urandom), lx, ly, lh, ls);
   endtask

   task automatic send_step(input logic [15:0] et, input logic signed [13:0] st,
                            input logic signed [15:0] ac);
      send_item(OP_STEP, et, st, ac, 32'($urandom), 32'($urandom), 16'($urandom),
                16'($urandom));
   endtask

   // drop valid, wait for all results, then let the block settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pose_fifo.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // register write, only while idle
   task automatic csr_write(input reg_type idx, input logic [15:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * int'(idx));
      csr_pwdata <= 32'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      if (idx == REG_WHEELBASE) wb_q = val;
      else mst_q = val;
   endtask

   // mostly realistic pose, sometimes full range
   function automatic logic signed [31:0] rand_pos();
      if ($urandom_range(9) < 8) return 32'(int'($urandom_range(2000000)) - 1000000);
      return 32'($urandom);
   endfunction

   task automatic random_items(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0)
            send_load(rand_pos(), rand_pos(), 16'(int'($urandom_range(51472)) - 25736),
                      16'($urandom));
         else if ($urandom_range(3) == 0)
            send_step(16'($urandom), 14'($urandom), 16'($urandom));
         else
            send_step(16'($urandom_range(8000)), 14'(int'($urandom_range(12000)) - 6000),
                      16'(int'($urandom_range(2000)) - 1000));
      end
   endtask

   // extremes of every field and the special cases
   task automatic test_directed;
      send_step(16'd3000, 14'sd0, 16'sd0);
      send_step(16'hFFFF, 14'sd6000, 16'sh7FFF);
      send_step(16'hFFFF, -14'sd6000, -16'sh8000);
      send_step(16'd0, 14'sh1FFF, 16'sd256);
      send_step(16'd5000, -14'sh2000, 16'sd1);
      send_load(32'sh7FFFFFF0, -32'sh7FFFFFF0, 16'sd25735, 16'hFFFF);
      send_step(16'hFFFF, 14'sd3000, 16'sh7FFF);
      send_step(16'hFFFF, 14'sd3000, 16'sh7FFF);
      send_load(-32'sh7FFFFFF0, 32'sh7FFFFFF0, -16'sd25736, 16'hFFFF);
      send_step(16'hFFFF, -14'sd6000, 16'sd0);
      send_load(32'sh7FFFFFFF, -32'sh80000000, 16'sh7FFF, 16'h0000);
      send_step(16'hFFFF, 14'sd100, -16'sd100);
      send_load(32'sd0, 32'sd0, -16'sh8000, 16'h0100);
      send_step(16'hFFFF, 14'sd0, -16'sh8000);
      send_load(32'sd0, 32'sd0, 16'sd12868, 16'h8000);
      send_step(16'd4000, 14'sd5000, 16'sd0);
      send_load(32'sd0, 32'sd0, -16'sd12868, 16'h4000);
      send_step(16'd4000, -14'sd5000, 16'sd0);
      drain();
   endtask

   task automatic test_config_extremes;
      csr_write(REG_WHEELBASE, 16'd0);
      csr_write(REG_MAX_STEP, 16'hFFFF);
      send_load(32'sd0, 32'sd0, 16'sd0, 16'hFFFF);
      send_step(16'hFFFF, 14'sd6000, 16'sd0);
      send_step(16'hFFFF, -14'sd5999, 16'sd0);
      random_items(60);
      drain();
      csr_write(REG_WHEELBASE, 16'hFFFF);
      csr_write(REG_MAX_STEP, 16'd0);
      random_items(60);
      drain();
      csr_write(REG_WHEELBASE, 16'd1);
      csr_write(REG_MAX_STEP, 16'd20000);
      random_items(60);
      drain();
   endtask

   task automatic test_random_phases;
      int idle[4]  = '{0, 66, 0, 31};
      int stall[4] = '{0, 0, 66, 31};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle[ph];
         rsp_stall_pct = stall[ph];
         csr_write(REG_WHEELBASE, 16'($urandom_range(65535, 1)));
         csr_write(REG_MAX_STEP, 16'($urandom));
         random_items(200);
         drain();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      pose_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_fifo.size() == 0) begin
            $error("result with no prediction waiting");
            errors++;
         end else begin
            e = pose_fifo.pop_front();
            if (rsp_pos_x !== e.pos_x) begin
               $error("pos_x expected %0d actual %0d", e.pos_x, rsp_pos_x); errors++;
            end
            if (rsp_pos_y !== e.pos_y) begin
               $error("pos_y expected %0d actual %0d", e.pos_y, rsp_pos_y); errors++;
            end
            if (rsp_heading !== e.heading) begin
               $error("heading expected %0d actual %0d", e.heading, rsp_heading); errors++;
            end
            if (rsp_speed !== e.speed) begin
               $error("speed expected %0d actual %0d", e.speed, rsp_speed); errors++;
            end
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      wb_q = WB_RESET;
      mst_q = MST_RESET;
      px_q = 0;
      py_q = 0;
      hd_q = 0;
      sp_q = SPEED_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random_phases();
      drain();
      if (errors == 0 && pose_fifo.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
